// File: design/b64d_pkg.sv
// Shared types, character codes and the alphabet lookup for the base64 decoder.
package b64d_pkg;

	// Characters with a meaning of their own.
	localparam logic [7:0] CHAR_SPACE = 8'h20;
	localparam logic [7:0] CHAR_TAB   = 8'h09;
	localparam logic [7:0] CHAR_LF    = 8'h0A;
	localparam logic [7:0] CHAR_FF    = 8'h0C;
	localparam logic [7:0] CHAR_CR    = 8'h0D;
	localparam logic [7:0] CHAR_PAD   = 8'h3D;
	localparam logic [7:0] CHAR_PLUS  = 8'h2B;
	localparam logic [7:0] CHAR_SLASH = 8'h2F;

	// Sextet values where the alphabet ranges start.
	localparam logic [5:0] SEXTET_LOWER = 6'd26;
	localparam logic [5:0] SEXTET_DIGIT = 6'd52;
	localparam logic [5:0] SEXTET_PLUS  = 6'd62;
	localparam logic [5:0] SEXTET_SLASH = 6'd63;

	// Result of an alphabet lookup.
	typedef struct packed {
		logic       hit;
		logic [5:0] value;
	} sextet_t;

	// One decoded group handed from the front to the back.
	// Bytes sit from the top of word; count says how many of them are real.
	typedef struct packed {
		logic [23:0] word;
		logic [1:0]  count;
		logic        eom;
		logic        bad;
	} job_t;

	// Maps a character to its six-bit value, or reports a miss.
	function automatic sextet_t sextet_of(input logic [7:0] c);
		sextet_t r;
		r.hit   = 1'b1;
		r.value = '0;
		case (c) inside
			[8'h41:8'h5A]: r.value = 6'(c - 8'h41);
			[8'h61:8'h7A]: r.value = SEXTET_LOWER + 6'(c - 8'h61);
			[8'h30:8'h39]: r.value = SEXTET_DIGIT + 6'(c - 8'h30);
			CHAR_PLUS:     r.value = SEXTET_PLUS;
			CHAR_SLASH:    r.value = SEXTET_SLASH;
			default:       r.hit = 1'b0;
		endcase
		return r;
	endfunction

	// True for the whitespace characters that the decoder skips.
	function automatic logic is_space(input logic [7:0] c);
		logic r;
		case (c) inside
			CHAR_SPACE, CHAR_TAB, CHAR_LF, CHAR_FF, CHAR_CR: r = 1'b1;
			default: r = 1'b0;
		endcase
		return r;
	endfunction

endpackage

// File: design/b64d_front.sv
// Front end: classifies each character, tracks group and pad state, builds jobs.
module b64d_front
	import b64d_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       accept,
	input  logic [7:0] char_code,
	input  logic       has_char,
	input  logic       last,
	output logic       push,
	output job_t       push_job
);

	logic [17:0] acc_q;
	logic [1:0]  grp_q;
	logic [1:0]  pad_q;
	logic        err_q;

	logic [17:0] acc_n;
	logic [1:0]  grp_n;
	logic [1:0]  pad_n;
	logic        err_n;
	sextet_t     sx;
	job_t        job;

	// Character step followed by the end-of-message checks.
	always_comb begin
		acc_n     = acc_q;
		grp_n     = grp_q;
		pad_n     = pad_q;
		err_n     = err_q;
		sx        = sextet_of(char_code);
		job.word  = '0;
		job.count = 2'd0;
		job.eom   = last;
		job.bad   = 1'b0;

		if (has_char && !is_space(char_code)) begin
			if (char_code == CHAR_PAD) begin
				if ((grp_q == 2'd2 && pad_q != 2'd2) || (grp_q == 2'd3 && pad_q == 2'd0)) begin
					pad_n = 2'(pad_q + 2'd1);
				end else begin
					err_n = 1'b1;
				end
			end else if (!sx.hit || pad_q != 2'd0) begin
				err_n = 1'b1;
			end else if (!err_q) begin
				if (grp_q == 2'd3) begin
					job.word  = {acc_q, sx.value};
					job.count = 2'd3;
					acc_n     = '0;
					grp_n     = 2'd0;
				end else begin
					acc_n = {acc_q[11:0], sx.value};
					grp_n = 2'(grp_q + 2'd1);
				end
			end
		end

		if (last) begin
			if (grp_n == 2'd1) begin
				err_n = 1'b1;
			end
			if (pad_n == 2'd1 && grp_n == 2'd2) begin
				err_n = 1'b1;
			end
			if (!err_n) begin
				if (grp_n == 2'd2) begin
					job.word  = {acc_n[11:4], 16'd0};
					job.count = 2'd1;
				end else if (grp_n == 2'd3) begin
					job.word  = {acc_n[17:2], 8'd0};
					job.count = 2'd2;
				end
			end
			job.bad = err_n;
		end
	end

	assign push     = accept && (job.count != 2'd0 || last);
	assign push_job = job;

	// Message state; a closing beat returns everything to reset values.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
			grp_q <= 2'd0;
			pad_q <= 2'd0;
			err_q <= 1'b0;
		end else if (accept) begin
			if (last) begin
				acc_q <= '0;
				grp_q <= 2'd0;
				pad_q <= 2'd0;
				err_q <= 1'b0;
			end else begin
				acc_q <= acc_n;
				grp_q <= grp_n;
				pad_q <= pad_n;
				err_q <= err_n;
			end
		end
	end

	// Padding only ever follows two or three sextets.
	a_pad_needs_group: assert property (@(posedge clk) disable iff (!arst_n)
		pad_q != 2'd0 |-> (grp_q == 2'd2 || grp_q == 2'd3))
		else $error("pad count set without a partial group");

endmodule

// File: design/b64d_queue.sv
// Short job queue that decouples the front end from the output sequencer.
module b64d_queue
	import b64d_pkg::*;
#(
	parameter int DEPTH = 4
)
(
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  job_t push_job,
	input  logic pop,
	output logic full,
	output logic head_valid,
	output job_t head_job
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	job_t          mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	assign full       = (count_q == CW'(DEPTH));
	assign head_valid = (count_q != '0);
	assign head_job   = mem_q[rd_ptr_q];

	// Storage writes.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : PW'(wr_ptr_q + 1'b1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : PW'(rd_ptr_q + 1'b1);
			end
			if (push && !pop) begin
				count_q <= CW'(count_q + 1'b1);
			end else if (pop && !push) begin
				count_q <= CW'(count_q - 1'b1);
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("job queue written while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head_valid)
		else $error("job queue read while empty");

endmodule

// File: design/b64d_back.sv
// Back end: walks each job byte by byte into the output register.
module b64d_back
	import b64d_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       head_valid,
	input  job_t       head_job,
	output logic       pop,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] data_byte,
	output logic       byte_valid,
	output logic       end_of_message,
	output logic       bad_encoding
);

	logic [1:0] k_q;
	logic       out_valid_q;
	logic [7:0] byte_q;
	logic       byte_valid_q;
	logic       eom_q;
	logic       bad_q;

	logic       load;
	logic       final_res;
	logic [7:0] sel_byte;

	// Pick the next byte of the head job and see whether it is the job's last.
	always_comb begin
		load = head_valid && (!out_valid_q || !out_stall);
		case (k_q)
			2'd0:    sel_byte = head_job.word[23:16];
			2'd1:    sel_byte = head_job.word[15:8];
			default: sel_byte = head_job.word[7:0];
		endcase
		final_res = (head_job.count == 2'd0) || (k_q == 2'(head_job.count - 2'd1));
	end

	assign pop = load && final_res;

	// Byte index within the head job.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q <= 2'd0;
		end else if (load) begin
			k_q <= final_res ? 2'd0 : 2'(k_q + 2'd1);
		end
	end

	// Output register valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (load) begin
			if (head_job.count == 2'd0) begin
				byte_q       <= 8'd0;
				byte_valid_q <= 1'b0;
			end else begin
				byte_q       <= sel_byte;
				byte_valid_q <= 1'b1;
			end
			eom_q <= head_job.eom && final_res;
			bad_q <= head_job.bad && final_res;
		end
	end

	assign out_valid      = out_valid_q;
	assign data_byte      = byte_q;
	assign byte_valid     = byte_valid_q;
	assign end_of_message = eom_q;
	assign bad_encoding   = bad_q;

	a_bad_on_final: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && bad_q |-> eom_q)
		else $error("error flag outside the final beat");

	a_empty_is_final: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !byte_valid_q |-> eom_q)
		else $error("empty beat that does not close a message");

	a_index_range: assert property (@(posedge clk) disable iff (!arst_n)
		head_valid |-> (k_q < head_job.count || k_q == 2'd0))
		else $error("byte index past the job's byte count");

endmodule

// File: design/base64_forgiving_decoder_core.sv
// A beat's job is written into the job queue, and output beats leave from a register.
// Throughput: one beat per cycle in while in_stall is low and out while out_stall is low.
// A full group of three bytes leaves as three output beats; the job queue of QUEUE_DEPTH
// entries absorbs it, and in_stall rises only when that queue is full.
// Reset: arst_n clears message state, queue pointers and output valid at once.
module base64_forgiving_decoder_core
	import b64d_pkg::*;
#(
	parameter int QUEUE_DEPTH = 4
)
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] char_code,
	input  logic       has_char,
	input  logic       last,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] data_byte,
	output logic       byte_valid,
	output logic       end_of_message,
	output logic       bad_encoding
);

	logic accept;
	logic push;
	job_t push_job;
	logic pop;
	logic full;
	logic head_valid;
	job_t head_job;

	// A beat enters whenever the queue has room for the job it may produce.
	assign in_stall = full;
	assign accept   = in_valid && !full;

	b64d_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.char_code (char_code),
		.has_char  (has_char),
		.last      (last),
		.push      (push),
		.push_job  (push_job)
	);

	b64d_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_job   (push_job),
		.pop        (pop),
		.full       (full),
		.head_valid (head_valid),
		.head_job   (head_job)
	);

	b64d_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.head_valid     (head_valid),
		.head_job       (head_job),
		.pop            (pop),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.data_byte      (data_byte),
		.byte_valid     (byte_valid),
		.end_of_message (end_of_message),
		.bad_encoding   (bad_encoding)
	);

endmodule

// File: dv/tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for the base64 decoder core: scoreboard and random traffic.
module tb
	import b64d_pkg::*;
;

	localparam int CLK_HALF     = 5;
	localparam int RESET_CYCLES = 8;
	localparam int RANDOM_ITEMS = 420;
	localparam int SETTLE       = 8;
	localparam int LONG_HOLD    = 300;
	localparam int CYCLE_LIMIT  = 200000;
	localparam int REPORT_MAX   = 10;

	// One output beat as the receiver sees it.
	typedef struct packed {
		logic [7:0] data;
		logic       valid;
		logic       eom;
		logic       bad;
	} dec_beat_t;

	// Tracks decoder state per message and checks output beats in order.
	class decode_scoreboard;
		dec_beat_t   pending[$];
		logic [17:0] acc;
		logic [1:0]  held;
		logic [1:0]  pads;
		logic        err;
		int          failures;
		int          checked;
		int          messages;
		int          bad_messages;
		int          data_bytes;

		function new();
			acc = '0;
			held = '0;
			pads = '0;
			err = 1'b0;
			failures = 0;
			checked = 0;
			messages = 0;
			bad_messages = 0;
			data_bytes = 0;
		endfunction

		function void push_beat(logic [7:0] d, logic v);
			dec_beat_t b;
			b.data = d;
			b.valid = v;
			b.eom = 1'b0;
			b.bad = 1'b0;
			pending.insert(pending.size(), b);
			if (v)
				data_bytes++;
		endfunction

		// Applies one accepted input beat and queues the bytes it should produce.
		function void note_char(logic [7:0] c, logic h, logic l);
			logic [5:0]  s;
			logic        hit;
			logic [23:0] w;
			dec_beat_t   tail;
			int          before_count;
			before_count = pending.size();
			if (h && !(c == CHAR_SPACE || c == CHAR_TAB || c == CHAR_LF ||
					c == CHAR_FF || c == CHAR_CR)) begin
				if (c == CHAR_PAD) begin
					if ((held == 2'd2 && pads < 2'd2) || (held == 2'd3 && pads == 2'd0))
						pads = pads + 2'd1;
					else
						err = 1'b1;
				end else begin
					hit = 1'b1;
					s = '0;
					if (c >= "A" && c <= "Z")
						s = 6'(c - "A");
					else if (c >= "a" && c <= "z")
						s = 6'(c - "a") + 6'd26;
					else if (c >= "0" && c <= "9")
						s = 6'(c - "0") + 6'd52;
					else if (c == CHAR_PLUS)
						s = 6'd62;
					else if (c == CHAR_SLASH)
						s = 6'd63;
					else
						hit = 1'b0;
					if (!hit || pads != 2'd0) begin
						err = 1'b1;
					end else if (!err) begin
						if (held == 2'd3) begin
							w = {acc, s};
							push_beat(w[23:16], 1'b1);
							push_beat(w[15:8], 1'b1);
							push_beat(w[7:0], 1'b1);
							acc = '0;
							held = '0;
						end else begin
							acc = {acc[11:0], s};
							held = held + 2'd1;
						end
					end
				end
			end

			// Closing checks, partial-group bytes and the final flags.
			if (l) begin
				if (held == 2'd1)
					err = 1'b1;
				if (pads == 2'd1 && held == 2'd2)
					err = 1'b1;
				if (!err) begin
					if (held == 2'd2) begin
						push_beat(acc[11:4], 1'b1);
					end else if (held == 2'd3) begin
						push_beat(acc[17:10], 1'b1);
						push_beat(acc[9:2], 1'b1);
					end
				end
				if (pending.size() == before_count)
					push_beat(8'h00, 1'b0);
				tail = pending[pending.size() - 1];
				tail.eom = 1'b1;
				tail.bad = err;
				pending[pending.size() - 1] = tail;
				messages++;
				if (err)
					bad_messages++;
				acc = '0;
				held = '0;
				pads = '0;
				err = 1'b0;
			end
		endfunction

		// Compares one output beat against the oldest expected beat.
		function void check_beat(dec_beat_t got);
			dec_beat_t want;
			if (pending.size() == 0) begin
				failures++;
				if (failures <= REPORT_MAX)
					$display("Unexpected beat: data %02h valid %b eom %b bad %b",
						got.data, got.valid, got.eom, got.bad);
				return;
			end
			want = pending.pop_front();
			checked++;
			if (got.data !== want.data || got.valid !== want.valid ||
					got.eom !== want.eom || got.bad !== want.bad) begin
				failures++;
				if (failures <= REPORT_MAX)
					$display("Beat %0d: expected data %02h valid %b eom %b bad %b, got %02h %b %b %b",
						checked, want.data, want.valid, want.eom, want.bad,
						got.data, got.valid, got.eom, got.bad);
			end
		endfunction
	endclass

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_stall;
	logic [7:0] char_code = 8'h00;
	logic       has_char = 1'b0;
	logic       last = 1'b0;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic [7:0] data_byte;
	logic       byte_valid;
	logic       end_of_message;
	logic       bad_encoding;

	logic       hold_ask = 1'b0;
	logic       hold_seen = 1'b0;
	int         hold_left = 0;
	int         stall_mode = 0;
	int         phase_left = 0;
	int         cycle_count = 0;
	int         burst_left = 0;
	int         items_sent = 0;

	logic [7:0] blanks [5] = '{CHAR_SPACE, CHAR_TAB, CHAR_LF, CHAR_FF, CHAR_CR};

	decode_scoreboard sb = new();

	base64_forgiving_decoder_core DUT (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.char_code      (char_code),
		.has_char       (has_char),
		.last           (last),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.data_byte      (data_byte),
		.byte_valid     (byte_valid),
		.end_of_message (end_of_message),
		.bad_encoding   (bad_encoding)
	);

	// Free-running clock.
	always begin
		#CLK_HALF clk = 1'b1;
		#CLK_HALF clk = 1'b0;
	end

	// Watchdog on the total run length.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles with %0d beats outstanding",
				cycle_count, sb.pending.size());
			$display("Verification failed");
			$finish;
		end
	end

	// Receiver back-pressure: random phases of different stall density, plus a long hold on request.
	always @(posedge clk) begin
		if (hold_left != 0) begin
			out_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else if (hold_ask != hold_seen) begin
			hold_seen <= hold_ask;
			hold_left <= LONG_HOLD;
			out_stall <= 1'b1;
		end else begin
			if (phase_left == 0) begin
				stall_mode <= $urandom_range(0, 3);
				phase_left <= $urandom_range(20, 200);
			end else begin
				phase_left <= phase_left - 1;
			end
			case (stall_mode)
				0: out_stall <= 1'b0;
				1: out_stall <= ($urandom_range(0, 3) == 0);
				2: out_stall <= 1'($urandom_range(0, 1));
				default: out_stall <= ($urandom_range(0, 3) != 0);
			endcase
		end
	end

	// Output monitor: every accepted output beat goes to the scoreboard.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_beat({data_byte, byte_valid, end_of_message, bad_encoding});
	end

	// Offers one input beat after any burst gap and waits until it is taken.
	task automatic offer(input logic [7:0] c, input logic h, input logic l);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		in_valid <= 1'b1;
		char_code <= c;
		has_char <= h;
		last <= l;
		do @(posedge clk); while (in_stall);
		sb.note_char(c, h, l);
		if (h || l)
			items_sent++;
	endtask

	task automatic send_text(input string s, input bit close);
		for (int i = 0; i < s.len(); i++)
			offer(8'(s[i]), 1'b1, close && i == s.len() - 1);
	endtask

	// Stops sending until every expected beat is back, then lets the pipe settle.
	task automatic drain_and_settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	function automatic logic [7:0] char_of(input logic [5:0] v);
		if (v < 6'd26)
			return 8'("A") + 8'(v);
		else if (v < 6'd52)
			return 8'("a") + 8'(v - 6'd26);
		else if (v < 6'd62)
			return 8'("0") + 8'(v - 6'd52);
		else if (v == 6'd62)
			return CHAR_PLUS;
		return CHAR_SLASH;
	endfunction

	// Builds one message, mostly well-formed with random content, and sends it.
	task automatic send_random_message();
		logic [7:0] msg[$];
		int         kind;
		int         n;
		int         pick;
		int         close_mode;
		kind = $urandom_range(0, 9);
		if (kind < 7) begin
			n = $urandom_range(0, 3) * 4 + $urandom_range(0, 3);
			if ($urandom_range(0, 15) == 0)
				n = n + 16;
			if (n % 4 == 1 && kind < 6)
				n++;
			for (int i = 0; i < n; i++)
				msg.insert(msg.size(), char_of(6'($urandom_range(0, 63))));
			if (n % 4 == 2 && $urandom_range(0, 1) == 1) begin
				msg.insert(msg.size(), CHAR_PAD);
				msg.insert(msg.size(), CHAR_PAD);
			end else if (n % 4 == 3 && $urandom_range(0, 1) == 1) begin
				msg.insert(msg.size(), CHAR_PAD);
			end
			// A broken variant: one character replaced by anything at all.
			if (kind == 6 && msg.size() != 0)
				msg[$urandom_range(0, msg.size() - 1)] = 8'($urandom_range(0, 255));
		end else begin
			n = $urandom_range(0, 8);
			for (int i = 0; i < n; i++) begin
				pick = $urandom_range(0, 3);
				case (pick)
					0: msg.insert(msg.size(), char_of(6'($urandom_range(0, 63))));
					1: msg.insert(msg.size(), CHAR_PAD);
					2: msg.insert(msg.size(), blanks[$urandom_range(0, 4)]);
					default: msg.insert(msg.size(), 8'($urandom_range(0, 255)));
				endcase
			end
		end

		close_mode = (msg.size() == 0) ? 1 : $urandom_range(0, 2);
		for (int i = 0; i < msg.size(); i++) begin
			if ($urandom_range(0, 7) == 0)
				offer(blanks[$urandom_range(0, 4)], 1'b1, 1'b0);
			if ($urandom_range(0, 19) == 0)
				offer(8'($urandom_range(0, 255)), 1'b0, 1'b0);
			offer(msg[i], 1'b1, close_mode == 0 && i == msg.size() - 1);
		end
		if (close_mode == 1)
			offer(8'($urandom_range(0, 255)), 1'b0, 1'b1);
		else if (close_mode == 2)
			offer(blanks[$urandom_range(0, 4)], 1'b1, 1'b1);
	endtask

	// Main sequence: reset, directed messages, random messages, drain and verdict.
	initial begin
		int msg_index;
		int directed_items;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Directed: empty message, full groups, padding rules, whitespace, bad characters.
		offer(8'h00, 1'b0, 1'b1);
		send_text("+/z9", 1'b1);
		send_text("Q\tQ==", 1'b1);
		send_text("QUI=\n", 1'b1);
		send_text("QQ=\r", 1'b1);
		send_text("\fQ", 1'b1);
		send_text("QQ=A", 1'b1);
		offer(8'hFF, 1'b0, 1'b0);
		offer(CHAR_PAD, 1'b1, 1'b0);
		offer(8'h00, 1'b1, 1'b0);
		offer(8'hFF, 1'b1, 1'b1);
		drain_and_settle();
		directed_items = items_sent;

		// Random traffic with up to two long receiver holds and periodic full drains.
		msg_index = 0;
		while (items_sent - directed_items < RANDOM_ITEMS) begin
			if (msg_index == 10 || msg_index == 60)
				hold_ask <= ~hold_ask;
			send_random_message();
			msg_index++;
			if (msg_index % 25 == 0)
				drain_and_settle();
		end

		drain_and_settle();
		$display("Run covered %0d messages (%0d flagged bad) over %0d character beats.",
			sb.messages, sb.bad_messages, items_sent);
		$display("Checked %0d output beats carrying %0d data bytes; %0d failures.",
			sb.checked, sb.data_bytes, sb.failures);
		if (sb.failures == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
